FILE: hw/rtl/mwo_pkg.sv
// Shared constants, types and tables for the multi-waveform oscillator.
package mwo_pkg;

  localparam int unsigned SampleBits  = 16;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned SineShift   = 33 - SampleBits;
  localparam int unsigned StepBits    = 5;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 24;

  localparam logic [31:0] TurnPerRad = 32'd683565276;
  localparam logic signed [33:0] CordicX0 = 34'sd652032874;

  // Register indexes
  localparam logic [CfgIdxBits-1:0] RegMode    = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegRate    = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegToneFrq = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegLfoAmp  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegLfoFrq  = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegLfoDly  = 3'd5;

  // Waveform codes
  localparam logic [1:0] ModeSine = 2'd0;
  localparam logic [1:0] ModeFm   = 2'd1;
  localparam logic [1:0] ModeSqr  = 2'd2;
  localparam logic [1:0] ModeSaw  = 2'd3;

  // Arctangent table in 32-bit turns
  function automatic logic [29:0] atan_turn(input logic [StepBits-1:0] k);
    logic [29:0] r;
    unique case (k)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Divider request and response
  typedef struct packed {
    logic        start;
    logic [57:0] num;
    logic [25:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [25:0] rem;
  } div_rsp_t;

  // CORDIC request and response
  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cor_req_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] sine;
  } cor_rsp_t;

endpackage

FILE: hw/rtl/mwo_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
module mwo_div
  import mwo_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [57:0] num_q, num_d;
  logic [25:0] den_q, den_d;
  logic [26:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic        done_q, done_d;
  logic [27:0] trial;
  logic [26:0] shifted;

  // Shift one numerator bit into the partial remainder and try subtract
  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    done_d  = 1'b0;
    shifted = {rem_q[25:0], num_q[57]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      num_d  = req_i.num;
      den_d  = req_i.den;
      // Top 26 bits of the numerator are below the divisor by construction
      rem_d  = {1'b0, req_i.num[57:32]};
      num_d  = {req_i.num[31:0], 26'd0};
      quo_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[56:0], 1'b0};
      if (!trial[27]) begin
        rem_d = trial[26:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q[25:0];

endmodule

FILE: hw/rtl/mwo_cordic.sv
// Iterative CORDIC rotator: one micro-rotation per cycle, sine out in Q.30.
module mwo_cordic
  import mwo_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cor_req_t req_i,
  output cor_rsp_t rsp_o
);

  logic                busy_q, busy_d, done_q, done_d;
  logic [StepBits-1:0] k_q, k_d;
  logic [1:0]          quad_q, quad_d;
  logic signed [33:0]  x_q, x_d, y_q, y_d, dx, dy;
  logic signed [31:0]  z_q, z_d, at;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    k_d    = k_q;
    quad_d = quad_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    dx     = y_q >>> k_q;
    dy     = x_q >>> k_q;
    at     = $signed({2'b00, atan_turn(k_q)});
    if (req_i.start) begin
      busy_d = 1'b1;
      k_d    = '0;
      quad_d = req_i.angle[31:30];
      x_d    = CordicX0;
      y_d    = '0;
      z_d    = $signed({2'b00, req_i.angle[29:0]});
    end else if (busy_q) begin
      // Rotate toward zero residual angle
      if (!z_q[31]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end
      k_d = k_q + 1'b1;
      if (k_q == StepBits'(CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q <= quad_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  // Fold the quadrant back in
  always_comb begin
    unique case (quad_q)
      2'd0:    rsp_o.sine = y_q;
      2'd1:    rsp_o.sine = x_q;
      2'd2:    rsp_o.sine = -y_q;
      default: rsp_o.sine = -x_q;
    endcase
  end
  assign rsp_o.done = done_q;

endmodule

FILE: hw/rtl/multi_waveform_oscillator.sv
// Top level: sequencer, registers and phase state of the oscillator.
//
// Usage: one beat on the slave stream carries an input sample (tdata) and a
// restart flag (tuser). The block adds the oscillator value for the current
// phase and returns one beat on the master stream: the saturated sum in
// tdata and the clip flag in tuser. Registers are written through the cfg
// port (index, data, enable); the user must write them only while the block
// is idle, as the block itself does not enforce it.
// Each beat runs a sequencer over one shared 32-step restoring divider and
// one 16-step CORDIC rotator plus a few multiply steps. Four divisions
// reduce both phases and both increments. Square needs only these; saw
// adds one more division, sine one more division and the rotation, FM two
// more divisions, two rotations and the multiply steps.
// s_axis_tready is low from acceptance until the result is loaded into the
// output register, so the next beat can be taken as soon as the result is
// valid. The output register is separate, so the next input beat can be
// taken while a result still waits; a stalled receiver then holds both the
// result and, after the next beat is done, the sequencer.
// Reset loads the register defaults, zeroes both phases and empties the
// output register; there is no clearing pass.
module multi_waveform_oscillator
  import mwo_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SampleBits-1:0]  s_axis_tdata,   // sample_in
  input  logic                   s_axis_tuser,   // restart
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [SampleBits-1:0]  m_axis_tdata,   // sample_out
  output logic                   m_axis_tuser,   // clipped
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  // Sequencer states
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StRedP   = 4'd1;
  localparam logic [3:0] StRedQ   = 4'd2;
  localparam logic [3:0] StRedTf  = 4'd3;
  localparam logic [3:0] StRedLf  = 4'd4;
  localparam logic [3:0] StTurnP  = 4'd5;
  localparam logic [3:0] StTurnQ  = 4'd6;
  localparam logic [3:0] StLfoCor = 4'd7;
  localparam logic [3:0] StDepth  = 4'd8;
  localparam logic [3:0] StFmMul  = 4'd9;
  localparam logic [3:0] StFmRad  = 4'd10;
  localparam logic [3:0] StTone   = 4'd11;
  localparam logic [3:0] StSaw    = 4'd12;
  localparam logic [3:0] StOut    = 4'd13;
  localparam logic [3:0] StWait   = 4'd14;

  localparam logic signed [SampleBits+1:0] SmpOne = 18'sd1 <<< (SampleBits - 3);
  localparam logic signed [SampleBits+1:0] SmpMax = (18'sd1 <<< (SampleBits - 1)) - 18'sd1;
  localparam logic signed [SampleBits+1:0] SmpMin = -(18'sd1 <<< (SampleBits - 1));

  // Configuration registers
  logic [1:0]  mode_q;
  logic [17:0] rate_q;
  logic [23:0] tone_frq_q, lfo_frq_q;
  logic [15:0] lfo_amp_q, lfo_dly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeSine;
      rate_q     <= 18'd48000;
      tone_frq_q <= 24'd112640;
      lfo_amp_q  <= '0;
      lfo_frq_q  <= '0;
      lfo_dly_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMode:    mode_q     <= cfg_data_i[1:0];
        RegRate:    rate_q     <= cfg_data_i[17:0];
        RegToneFrq: tone_frq_q <= cfg_data_i;
        RegLfoAmp:  lfo_amp_q  <= cfg_data_i[15:0];
        RegLfoFrq:  lfo_frq_q  <= cfg_data_i;
        RegLfoDly:  lfo_dly_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [25:0] wrap;
  assign wrap = {(rate_q == '0) ? 18'd1 : rate_q, 8'd0};

  // Sequencer state
  logic [3:0]  st_q, st_d;
  logic        wait_q, wait_d;
  logic [25:0] tph_q, tph_d, lph_q, lph_d;
  logic [25:0] p_q, p_d, q_q, q_d, tr_q, tr_d;
  logic [31:0] ang_q, ang_d, lfo_turn_q, lfo_turn_d;
  logic signed [SampleBits-1:0] smp_q, smp_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [SampleBits+1:0] wave_q, wave_d;
  logic [SampleBits-1:0] out_data_q, out_data_d;
  logic        out_clip_q, out_clip_d, out_vld_q, out_vld_d;

  div_req_t div_req;
  div_rsp_t div_rsp;
  cor_req_t cor_req;
  cor_rsp_t cor_rsp;

  mwo_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  mwo_cordic u_cor (.clk_i, .rst_ni, .req_i(cor_req), .rsp_o(cor_rsp));

  // Radians Q.20 to turns: hi*K + (lo*K)>>20, modulo 2^32
  function automatic logic [31:0] rad_turn(input logic signed [63:0] v);
    logic [31:0] hi;
    logic [51:0] lo;
    hi = v[51:20];
    lo = {32'd0, v[19:0]} * {20'd0, TurnPerRad};
    return hi * TurnPerRad + lo[51:20];
  endfunction

  logic signed [SampleBits+1:0] sum;
  logic signed [33:0] rnd;
  logic [26:0] psum;
  logic signed [57:0] prod;

  always_comb begin
    st_d       = st_q;
    wait_d     = wait_q;
    tph_d      = tph_q;
    lph_d      = lph_q;
    p_d        = p_q;
    q_d        = q_q;
    tr_d       = tr_q;
    ang_d      = ang_q;
    lfo_turn_d = lfo_turn_q;
    smp_d      = smp_q;
    acc_d      = acc_q;
    wave_d     = wave_q;
    out_data_d = out_data_q;
    out_clip_d = out_clip_q;
    out_vld_d  = out_vld_q;
    div_req    = '0;
    cor_req    = '0;
    rnd        = '0;
    sum        = '0;
    psum       = '0;
    prod       = '0;
    if (m_axis_tready) out_vld_d = 1'b0;

    unique case (st_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          smp_d = s_axis_tdata;
          if (s_axis_tuser) begin
            tph_d = '0;
            lph_d = '0;
          end
          // Reduce tone phase modulo W
          div_req.start = 1'b1;
          div_req.num   = {32'd0, s_axis_tuser ? 26'd0 : tph_q};
          div_req.den   = wrap;
          st_d   = StRedP;
          wait_d = 1'b1;
        end
      end
      StRedP: begin
        if (wait_q) wait_d = 1'b0;
        else if (div_rsp.done) begin
          p_d = div_rsp.rem;
          div_req.start = 1'b1;
          div_req.num   = {32'd0, lph_q};
          div_req.den   = wrap;
          st_d = StRedQ; wait_d = 1'b1;
        end
      end
      StRedQ: begin
        if (wait_q) wait_d = 1'b0;
        else if (div_rsp.done) begin
          q_d = div_rsp.rem;
          div_req.start = 1'b1;
          div_req.num   = {34'd0, tone_frq_q};
          div_req.den   = wrap;
          st_d = StRedTf; wait_d = 1'b1;
        end
      end
      StRedTf: begin
        if (wait_q) wait_d = 1'b0;
        else if (div_rsp.done) begin
          tr_d = div_rsp.rem;
          div_req.start = 1'b1;
          div_req.num   = {34'd0, lfo_frq_q};
          div_req.den   = wrap;
          st_d = StRedLf; wait_d = 1'b1;
        end
      end
      StRedLf: begin
        if (wait_q) wait_d = 1'b0;
        else if (div_rsp.done) begin
          // Advance both phases for the next beat
          psum  = {1'b0, p_q} + {1'b0, tr_q};
          tph_d = (psum >= {1'b0, wrap}) ? 26'(psum - {1'b0, wrap}) : psum[25:0];
          psum  = {1'b0, q_q} + {1'b0, div_rsp.rem};
          lph_d = (psum >= {1'b0, wrap}) ? 26'(psum - {1'b0, wrap}) : psum[25:0];
          unique case (mode_q)
            ModeSqr: begin
              wave_d = ({p_q, 1'b0} <= {1'b0, wrap}) ? SmpOne : -SmpOne;
              st_d = StOut;
            end
            ModeSaw: begin
              div_req.start = 1'b1;
              div_req.num   = 58'({p_q, 1'b0}) << (SampleBits - 3);
              div_req.den   = wrap;
              st_d = StSaw; wait_d = 1'b1;
            end
            ModeFm: begin
              div_req.start = 1'b1;
              div_req.num   = {q_q, 32'd0};
              div_req.den   = wrap;
              st_d = StTurnQ; wait_d = 1'b1;
            end
            default: begin
              div_req.start = 1'b1;
              div_req.num   = {p_q, 32'd0};
              div_req.den   = wrap;
              st_d = StTurnP; wait_d = 1'b1;
            end
          endcase
        end
      end
      StSaw: begin
        if (wait_q) wait_d = 1'b0;
        else if (div_rsp.done) begin
          wave_d = $signed({1'b0, div_rsp.quo[SampleBits:0]}) - SmpOne;
          st_d = StOut;
        end
      end
      StTurnQ: begin
        if (wait_q) wait_d = 1'b0;
        else if (div_rsp.done) begin
          lfo_turn_d = div_rsp.quo;
          acc_d = 64'($signed({1'b0, lfo_frq_q}) * $signed(lfo_dly_q));
          st_d = StLfoCor;
          wait_d = 1'b1;
        end
      end
      StLfoCor: begin
        if (wait_q) begin
          wait_d = 1'b0;
          cor_req.start = 1'b1;
          cor_req.angle = lfo_turn_q + rad_turn(acc_q);
          // Start the tone phase turn meanwhile
          div_req.start = 1'b1;
          div_req.num   = {p_q, 32'd0};
          div_req.den   = wrap;
        end else if (cor_rsp.done) begin
          // Hold the rounded LFO sine until the slower divider ends
          rnd = (cor_rsp.sine + 34'sd16384) >>> 15;
          acc_d = 64'(rnd);
        end else if (div_rsp.done) begin
          lfo_turn_d = div_rsp.quo;
          st_d = StDepth;
        end
      end
      StDepth: begin
        acc_d = 64'($signed({1'b0, tone_frq_q}) * $signed(lfo_amp_q));
        smp_d = smp_q;
        ang_d = acc_q[31:0];
        st_d = StFmMul;
      end
      StFmMul: begin
        prod  = $signed(acc_q[40:0]) * $signed(ang_q[16:0]);
        acc_d = 64'(prod);
        st_d = StFmRad;
      end
      StFmRad: begin
        ang_d = lfo_turn_q + rad_turn(acc_q >>> 15);
        st_d = StTone; wait_d = 1'b1;
      end
      StTurnP: begin
        if (wait_q) wait_d = 1'b0;
        else if (div_rsp.done) begin
          ang_d = div_rsp.quo;
          st_d = StTone; wait_d = 1'b1;
        end
      end
      StTone: begin
        if (wait_q) begin
          wait_d = 1'b0;
          cor_req.start = 1'b1;
          cor_req.angle = ang_q;
        end else if (cor_rsp.done) begin
          rnd = (cor_rsp.sine + (34'sd1 <<< (SineShift - 1))) >>> SineShift;
          wave_d = rnd[SampleBits+1:0];
          st_d = StOut;
        end
      end
      StOut: begin
        // Saturate and load the output register
        if (!out_vld_q || m_axis_tready) begin
          sum = $signed({{2{smp_q[SampleBits-1]}}, smp_q}) + wave_q;
          out_clip_d = 1'b0;
          out_data_d = sum[SampleBits-1:0];
          if (sum > SmpMax) begin
            out_data_d = SmpMax[SampleBits-1:0];
            out_clip_d = 1'b1;
          end else if (sum < SmpMin) begin
            out_data_d = SmpMin[SampleBits-1:0];
            out_clip_d = 1'b1;
          end
          out_vld_d = 1'b1;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      wait_q    <= 1'b0;
      tph_q     <= '0;
      lph_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      wait_q    <= wait_d;
      tph_q     <= tph_d;
      lph_q     <= lph_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    q_q        <= q_d;
    tr_q       <= tr_d;
    ang_q      <= ang_d;
    lfo_turn_q <= lfo_turn_d;
    smp_q      <= smp_d;
    acc_q      <= acc_d;
    wave_q     <= wave_d;
    out_data_q <= out_data_d;
    out_clip_q <= out_clip_d;
  end

  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_clip_q;

  // Stored tone phase is below the wrap point as each beat ends
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIdle && $past(st_q) == StOut) |-> (tph_q < wrap))
    else $error("tone phase beyond wrap");

  // A result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StOut && out_vld_q && !m_axis_tready) |=> (st_q == StOut))
    else $error("output overwritten");

  // Clip flag implies a rail value
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata == SmpMax[SampleBits-1:0] || m_axis_tdata == SmpMin[SampleBits-1:0]))
    else $error("clip without saturation");

endmodule

FILE: dv/tb_multi_waveform_oscillator.sv
// Self-checking testbench for the multi-waveform oscillator stream block.
module tb_multi_waveform_oscillator;
  import mwo_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 300;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [SampleBits-1:0]  s_axis_tdata;   // sample_in
  logic                   s_axis_tuser;   // restart
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [SampleBits-1:0]  m_axis_tdata;   // sample_out
  logic                   m_axis_tuser;   // clipped
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  typedef struct {
    logic [SampleBits-1:0] smp;
    logic                  clip;
  } osc_out_t;

  // Shadow registers and phase state of the predictor
  logic [1:0]  sh_mode;
  logic [17:0] sh_rate;
  logic [23:0] sh_tone;
  logic [15:0] sh_lamp;
  logic [23:0] sh_lfrq;
  logic [15:0] sh_ldly;
  logic [31:0] tone_ph;
  logic [31:0] lfo_ph;

  osc_out_t expected_q[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  multi_waveform_oscillator DUT (.*);

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint floor_shr(longint v, int unsigned k);
    return v >>> k;
  endfunction

  function automatic logic [31:0] rad_to_turn(longint v);
    logic [31:0] hi;
    longint unsigned lo;
    hi = 32'(floor_shr(v, 20));
    lo = longint'(v) & 64'hFFFFF;
    return hi * TurnPerRad + 32'((lo * TurnPerRad) >> 20);
  endfunction

  function automatic logic [31:0] turn_of(logic [31:0] p, logic [31:0] w);
    longint unsigned n;
    n = longint'(p) << 32;
    return 32'(n / w);
  endfunction

  // Sine of a 32-bit turn angle, Q.30
  function automatic longint cordic_sin(logic [31:0] ang);
    longint x, y, z, dx, dy, a;
    x = CordicX0;
    y = 0;
    z = longint'(ang[29:0]);
    for (int k = 0; k < CordicSteps && k < 24; k++) begin
      dx = floor_shr(y, k);
      dy = floor_shr(x, k);
      a = longint'(atan_turn(5'(k)));
      if (z >= 0) begin
        x -= dx; y += dy; z -= a;
      end else begin
        x += dx; y -= dy; z += a;
      end
    end
    case (ang[31:30])
      2'd0: return y;
      2'd1: return x;
      2'd2: return -y;
      default: return -x;
    endcase
  endfunction

  // Oscillator value plus input, saturated; advance both phases
  function automatic osc_out_t predict_mixed_sample(logic [SampleBits-1:0] din, logic rst_ph);
    osc_out_t r;
    logic [31:0] w, p, q, la, ta;
    longint one, wave, sum, s, depth, dly;
    one = longint'(1) << (SampleBits - 3);
    w = ((sh_rate == 0) ? 32'd1 : 32'(sh_rate)) * 32'd256;
    if (rst_ph) begin
      tone_ph = 0;
      lfo_ph = 0;
    end
    p = tone_ph % w;
    q = lfo_ph % w;
    case (sh_mode)
      ModeSine: wave = floor_shr(cordic_sin(turn_of(p, w)) + (longint'(1) << (SineShift - 1)),
                                 SineShift);
      ModeFm: begin
        dly = longint'(sh_lfrq) * longint'($signed(sh_ldly));
        la = turn_of(q, w) + rad_to_turn(dly);
        s = floor_shr(cordic_sin(la) + (longint'(1) << 14), 15);
        depth = longint'(sh_tone) * longint'($signed(sh_lamp));
        ta = turn_of(p, w) + rad_to_turn(floor_shr(depth * s, 15));
        wave = floor_shr(cordic_sin(ta) + (longint'(1) << (SineShift - 1)), SineShift);
      end
      ModeSqr: wave = (longint'(p) * 2 <= longint'(w)) ? one : -one;
      default: wave = (longint'(p) * 2 * one) / longint'(w) - one;
    endcase
    sum = longint'($signed(din)) + wave;
    r.clip = 1'b0;
    if (sum > one * 4 - 1) begin sum = one * 4 - 1; r.clip = 1'b1; end
    if (sum < -one * 4) begin sum = -one * 4; r.clip = 1'b1; end
    r.smp = SampleBits'(sum);
    tone_ph = (p + sh_tone % w) % w;
    lfo_ph = (q + sh_lfrq % w) % w;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Receiver: random stall, check each accepted beat
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    osc_out_t e;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata, 0);
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata !== e.smp)
            report_mismatch("sample_out", $signed(m_axis_tdata), $signed(e.smp));
          if (m_axis_tuser !== e.clip) report_mismatch("clipped", m_axis_tuser, e.clip);
        end
      end
    end
  end

  // Send one sample beat and queue its prediction on acceptance
  task automatic send_sample(logic [SampleBits-1:0] din, logic rst_ph);
    // Leave the previous drive step behind before driving again
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= din;
    s_axis_tuser <= rst_ph;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(predict_mixed_sample(din, rst_ph));
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Write one register while idle
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegMode:    sh_mode = val[1:0];
      RegRate:    sh_rate = val[17:0];
      RegToneFrq: sh_tone = val[23:0];
      RegLfoAmp:  sh_lamp = val[15:0];
      RegLfoFrq:  sh_lfrq = val[23:0];
      RegLfoDly:  sh_ldly = val[15:0];
      default: ;
    endcase
  endtask

  task automatic rand_sample_burst(int n);
    for (int i = 0; i < n; i++) begin
      logic [SampleBits-1:0] d;
      d = 16'($urandom);
      if ($urandom_range(3) == 0) d = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      send_sample(d, $urandom_range(15) == 0);
    end
  endtask

  // Directed: field extremes and restart in each waveform
  task automatic test_directed();
    logic [1:0] modes[4] = '{ModeSine, ModeFm, ModeSqr, ModeSaw};
    write_reg(RegLfoAmp, 24'h1000);
    write_reg(RegLfoFrq, 24'd1280);
    write_reg(RegLfoDly, 24'h4000);
    foreach (modes[m]) begin
      wait_drained();
      write_reg(RegMode, 24'(modes[m]));
      send_sample(16'h7FFF, 1'b1);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'h5555, 1'b0);
      send_sample(16'hAAAA, 1'b0);
    end
    wait_drained();
  endtask

  // Zero rate, rate shrink with a stored phase, and register extremes
  task automatic test_rate_edges();
    write_reg(RegMode, 24'(ModeSaw));
    write_reg(RegRate, 24'd192000);
    write_reg(RegToneFrq, 24'hFFFFFF);
    rand_sample_burst(5);
    wait_drained();
    write_reg(RegRate, 24'd3);
    rand_sample_burst(3);
    wait_drained();
    write_reg(RegRate, 24'd0);
    write_reg(RegMode, 24'(ModeSqr));
    rand_sample_burst(3);
    wait_drained();
    write_reg(RegMode, 24'(ModeFm));
    write_reg(RegRate, 24'd1);
    write_reg(RegLfoAmp, 24'h8000);
    write_reg(RegLfoDly, 24'h7FFF);
    write_reg(RegLfoFrq, 24'hFFFFFF);
    rand_sample_burst(4);
    wait_drained();
  endtask

  // Random registers and samples under each idling phase
  task automatic test_random(int unsigned sidle, int unsigned rstall, int n);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int blk = 0; blk < n / 25; blk++) begin
      write_reg(RegMode, 24'($urandom_range(3)));
      write_reg(RegRate, $urandom_range(4) == 0 ? 24'($urandom_range(192000))
                                               : 24'($urandom_range(48000, 8000)));
      write_reg(RegToneFrq, $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(2560000)));
      write_reg(RegLfoAmp, 24'($urandom_range(65535)));
      write_reg(RegLfoFrq, $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(5120)));
      write_reg(RegLfoDly, 24'($urandom_range(65535)));
      rand_sample_burst(25);
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    sh_mode = ModeSine;
    sh_rate = 18'd48000;
    sh_tone = 24'd112640;
    sh_lamp = '0;
    sh_lfrq = '0;
    sh_ldly = '0;
    tone_ph = 0;
    lfo_ph = 0;
    mismatches = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    // Reset defaults first
    rand_sample_burst(4);
    wait_drained();
    test_directed();
    test_rate_edges();
    test_random(0, 0, 150);
    test_random(85, 0, 100);
    test_random(0, 85, 100);
    test_random(34, 34, 150);
    wait_drained();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
